>>> rtl/tsa_pkg.sv
package tsa_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_THRUST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADMAN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT  = 2'd2;

    localparam logic       OP_FRAME = 1'b0;
    localparam logic       OP_TICK  = 1'b1;

    localparam logic [1:0] FK_CMD        = 2'd0;
    localparam logic [1:0] FK_CONNECT    = 2'd1;
    localparam logic [1:0] FK_DISCONNECT = 2'd2;

    localparam logic [1:0] ACK_OK   = 2'd0;
    localparam logic [1:0] ACK_BUSY = 2'd1;
    localparam logic [1:0] ACK_BYE  = 2'd2;

    localparam logic       KIND_ACK  = 1'b0;
    localparam logic       KIND_SNAP = 1'b1;

    localparam logic [14:0] FULL_SCALE    = 15'd25600;
    localparam logic [14:0] MAX_THRUST_RST = 15'd25600;
    localparam logic [15:0] DEADMAN_RST   = 16'd10;
    localparam logic [15:0] HEARTBEAT_RST = 16'd2;
    localparam logic [15:0] AGE_MAX       = 16'hFFFF;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic               op;
        logic [1:0]         frame_kind;
        logic [31:0]        src_ip;
        logic [15:0]        sender_port;
        logic [31:0]        session_id;
        logic [31:0]        seq;
        logic [4:0]         field_present;
        logic signed [15:0] thrust_left;
        logic signed [15:0] thrust_right;
        logic               estop_request;
        logic signed [15:0] surge_in;
        logic signed [15:0] yaw_in;
    } t_in_word;

    typedef struct packed {
        logic               kind;
        logic [1:0]         ack_code;
        logic [31:0]        ack_seq;
        logic [31:0]        dest_ip;
        logic [15:0]        dest_port;
        logic               claim;
        logic               estop_out;
        logic signed [15:0] surge_out;
        logic signed [15:0] yaw_out;
        logic signed [15:0] thrust_left_out;
        logic signed [15:0] thrust_right_out;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic [1:0] n;
        t_out_word  w0;
        t_out_word  w1;
    } t_push;

endpackage

>>> rtl/tsa_ifs.sv
interface tsa_in_if;
    import tsa_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface tsa_out_if;
    import tsa_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> rtl/tsa_core.sv
module tsa_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  tsa_pkg::t_in_word                   i_word,
    input  logic                                i_cfg_we,
    input  logic [tsa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tsa_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output tsa_pkg::t_push                      o_push
);
    import tsa_pkg::*;

    logic [14:0]        r_max_thrust;
    logic [15:0]        r_deadman;
    logic [15:0]        r_heartbeat;

    logic               r_active,     n_active;
    logic [31:0]        r_owner_ip,   n_owner_ip;
    logic [15:0]        r_owner_port, n_owner_port;
    logic [31:0]        r_owner_sid,  n_owner_sid;
    logic [31:0]        r_last_seq,   n_last_seq;
    logic [15:0]        r_rx_age,     n_rx_age;
    logic [15:0]        r_ack_age,    n_ack_age;
    logic signed [15:0] r_left,       n_left;
    logic signed [15:0] r_right,      n_right;
    logic signed [15:0] r_surge,      n_surge;
    logic signed [15:0] r_yaw,        n_yaw;
    logic               r_estop,      n_estop;

    logic [14:0]        lim;
    logic               is_owner;
    logic               base_zero;
    logic signed [15:0] b_left, b_right, b_surge, b_yaw;
    logic               b_estop;
    logic signed [16:0] c_left, c_right, c_sum, c_diff, c_surge, c_yaw;
    logic signed [15:0] a_left, a_right, a_surge, a_yaw;
    logic               a_estop;
    logic [15:0]        fa_inc, aa_inc;
    t_push              push;

    function automatic logic signed [16:0] clip17(input logic signed [16:0] x,
                                                  input logic [14:0] l);
        logic signed [16:0] sl;
        sl = signed'({2'b00, l});
        if (x > sl) begin
            return sl;
        end else if (x < -sl) begin
            return -sl;
        end
        return x;
    endfunction

    function automatic t_out_word mk_ack(input logic [1:0] t, input logic [31:0] sq,
                                         input logic [31:0] ip, input logic [15:0] port,
                                         input logic act, input logic es);
        t_out_word w;
        w           = '0;
        w.kind      = KIND_ACK;
        w.ack_code  = t;
        w.ack_seq   = sq;
        w.dest_ip   = ip;
        w.dest_port = port;
        w.claim     = act;
        w.estop_out = es;
        return w;
    endfunction

    function automatic t_out_word mk_snap(input logic act, input logic es,
                                          input logic signed [15:0] s,
                                          input logic signed [15:0] y,
                                          input logic signed [15:0] l,
                                          input logic signed [15:0] r);
        t_out_word w;
        logic      drv;
        drv       = act && !es;
        w         = '0;
        w.kind    = KIND_SNAP;
        w.claim   = act;
        w.estop_out = es;
        if (drv) begin
            w.surge_out        = s;
            w.yaw_out          = y;
            w.thrust_left_out  = l;
            w.thrust_right_out = r;
        end
        return w;
    endfunction

    // command path
    always_comb begin
        lim       = (r_max_thrust > FULL_SCALE) ? FULL_SCALE : r_max_thrust;
        base_zero = !r_active;
        b_left    = base_zero ? '0 : r_left;
        b_right   = base_zero ? '0 : r_right;
        b_surge   = base_zero ? '0 : r_surge;
        b_yaw     = base_zero ? '0 : r_yaw;
        b_estop   = base_zero ? 1'b0 : r_estop;

        c_left  = i_word.field_present[0] ? signed'({i_word.thrust_left[15], i_word.thrust_left})
                                          : signed'({b_left[15], b_left});
        c_right = i_word.field_present[1]
                ? signed'({i_word.thrust_right[15], i_word.thrust_right})
                : signed'({b_right[15], b_right});
        c_left  = clip17(c_left, lim);
        c_right = clip17(c_right, lim);
        a_estop = i_word.field_present[2] ? i_word.estop_request : b_estop;
        c_sum   = c_left + c_right;
        c_diff  = c_left - c_right;
        if (i_word.field_present[4:3] == 2'b00) begin
            c_surge = c_sum >>> 1;
            c_yaw   = c_diff >>> 1;
        end else begin
            c_surge = i_word.field_present[3] ? signed'({i_word.surge_in[15], i_word.surge_in})
                                              : signed'({b_surge[15], b_surge});
            c_yaw   = i_word.field_present[4] ? signed'({i_word.yaw_in[15], i_word.yaw_in})
                                              : signed'({b_yaw[15], b_yaw});
        end
        c_surge = clip17(c_surge, FULL_SCALE);
        c_yaw   = clip17(c_yaw, FULL_SCALE);
        a_left  = c_left[15:0];
        a_right = c_right[15:0];
        a_surge = c_surge[15:0];
        a_yaw   = c_yaw[15:0];
    end

    // session control and results
    always_comb begin
        n_active     = r_active;
        n_owner_ip   = r_owner_ip;
        n_owner_port = r_owner_port;
        n_owner_sid  = r_owner_sid;
        n_last_seq   = r_last_seq;
        n_rx_age     = r_rx_age;
        n_ack_age    = r_ack_age;
        n_left       = r_left;
        n_right      = r_right;
        n_surge      = r_surge;
        n_yaw        = r_yaw;
        n_estop      = r_estop;
        push         = '0;

        is_owner = (i_word.src_ip == r_owner_ip) && (i_word.sender_port == r_owner_port)
                && (i_word.session_id == r_owner_sid);
        fa_inc   = (r_rx_age != AGE_MAX) ? r_rx_age + 16'd1 : r_rx_age;
        aa_inc   = (r_ack_age != AGE_MAX) ? r_ack_age + 16'd1 : r_ack_age;

        if (i_word.op == OP_TICK) begin
            n_rx_age  = fa_inc;
            n_ack_age = aa_inc;
            if (r_active && (fa_inc >= r_deadman)) begin
                n_active = 1'b0;
                n_left   = '0;
                n_right  = '0;
                n_estop  = 1'b0;
                push.w0  = mk_snap(1'b0, 1'b0, r_surge, r_yaw, '0, '0);
                push.w1  = mk_snap(1'b0, 1'b0, r_surge, r_yaw, '0, '0);
                push.n   = 2'd2;
            end else begin
                push.w0 = mk_snap(r_active, r_estop, r_surge, r_yaw, r_left, r_right);
                push.n  = 2'd1;
                if (r_active && (r_heartbeat != '0) && (aa_inc >= r_heartbeat)) begin
                    push.w1   = mk_ack(ACK_OK, r_last_seq, r_owner_ip, r_owner_port,
                                       1'b1, r_estop);
                    push.n    = 2'd2;
                    n_ack_age = '0;
                end
            end
        end else if (!r_active) begin
            n_ack_age = '0;
            push.n    = 2'd1;
            if ((i_word.frame_kind == FK_CMD) || (i_word.frame_kind == FK_CONNECT)) begin
                n_active     = 1'b1;
                n_owner_ip   = i_word.src_ip;
                n_owner_port = i_word.sender_port;
                n_owner_sid  = i_word.session_id;
                n_last_seq   = i_word.seq;
                n_rx_age     = '0;
                if (i_word.frame_kind == FK_CMD) begin
                    n_left  = a_left;
                    n_right = a_right;
                    n_surge = a_surge;
                    n_yaw   = a_yaw;
                    n_estop = a_estop;
                end else begin
                    n_left  = '0;
                    n_right = '0;
                    n_surge = '0;
                    n_yaw   = '0;
                    n_estop = 1'b0;
                end
                push.w0 = mk_ack(ACK_OK, i_word.seq, i_word.src_ip, i_word.sender_port,
                                 1'b1, n_estop);
            end else begin
                push.w0 = mk_ack(ACK_BYE, i_word.seq, i_word.src_ip, i_word.sender_port,
                                 1'b0, r_estop);
            end
        end else if (!is_owner) begin
            n_ack_age = '0;
            push.n    = 2'd1;
            push.w0   = mk_ack(ACK_BUSY, i_word.seq, i_word.src_ip, i_word.sender_port,
                               1'b1, r_estop);
        end else if (i_word.seq > r_last_seq) begin
            n_last_seq = i_word.seq;
            n_rx_age   = '0;
            n_ack_age  = '0;
            if (i_word.frame_kind == FK_DISCONNECT) begin
                push.w0  = mk_ack(ACK_BYE, i_word.seq, i_word.src_ip, i_word.sender_port,
                                  1'b1, r_estop);
                push.w1  = mk_snap(1'b0, 1'b0, r_surge, r_yaw, '0, '0);
                push.n   = 2'd2;
                n_active = 1'b0;
                n_left   = '0;
                n_right  = '0;
                n_estop  = 1'b0;
            end else begin
                n_left  = a_left;
                n_right = a_right;
                n_surge = a_surge;
                n_yaw   = a_yaw;
                n_estop = a_estop;
                push.w0 = mk_ack(ACK_OK, i_word.seq, i_word.src_ip, i_word.sender_port,
                                 1'b1, a_estop);
                push.n  = 2'd1;
            end
        end

        if (push.n == 2'd2) begin
            push.w1.last = 1'b1;
        end else begin
            push.w0.last = 1'b1;
        end
        if (!i_accept) begin
            push.n = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_thrust <= MAX_THRUST_RST;
            r_deadman    <= DEADMAN_RST;
            r_heartbeat  <= HEARTBEAT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_THRUST: r_max_thrust <= i_cfg_data[14:0];
                CFG_DEADMAN:    r_deadman    <= i_cfg_data[15:0];
                CFG_HEARTBEAT:  r_heartbeat  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_owner_ip   <= '0;
            r_owner_port <= '0;
            r_owner_sid  <= '0;
            r_last_seq   <= '0;
            r_rx_age     <= '0;
            r_ack_age    <= '0;
            r_left       <= '0;
            r_right      <= '0;
            r_surge      <= '0;
            r_yaw        <= '0;
            r_estop      <= 1'b0;
        end else if (i_accept) begin
            r_active     <= n_active;
            r_owner_ip   <= n_owner_ip;
            r_owner_port <= n_owner_port;
            r_owner_sid  <= n_owner_sid;
            r_last_seq   <= n_last_seq;
            r_rx_age     <= n_rx_age;
            r_ack_age    <= n_ack_age;
            r_left       <= n_left;
            r_right      <= n_right;
            r_surge      <= n_surge;
            r_yaw        <= n_yaw;
            r_estop      <= n_estop;
        end
    end

endmodule

>>> rtl/tsa_queue.sv
module tsa_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsa_pkg::t_push     i_push,
    input  logic               i_pop,
    output logic               o_room,
    output logic               o_valid,
    output tsa_pkg::t_out_word o_word
);
    import tsa_pkg::*;

    t_out_word        r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr, n_wr;
    logic [Q_AW-1:0]  r_rd, n_rd;
    logic [Q_AW:0]    r_count, n_count;
    logic             pop;
    logic [Q_AW-1:0]  wr_next;

    assign o_room  = r_count <= (Q_AW+1)'(Q_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_word  = r_mem[r_rd];
    assign pop     = i_pop && o_valid;
    assign wr_next = r_wr + Q_AW'(1);

    always_comb begin
        n_wr    = r_wr + Q_AW'(i_push.n);
        n_rd    = pop ? r_rd + Q_AW'(1) : r_rd;
        n_count = r_count + (Q_AW+1)'(i_push.n) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.w0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wr_next] <= i_push.w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/teleop_session_arbiter.sv
// Remote-control session arbiter. Each accepted word (a parsed command frame or a time
// tick) is resolved in the cycle it is taken: session ownership, sequence filtering,
// thrust clipping and the deadman are updated at once; the result words (none for a
// stale owner frame, else one or two) go to a four-word queue, from which one word
// leaves per cycle while the output is ready, last marking the final word of each
// input. The input side is ready whenever the queue has at least two free slots, so an
// input word can be taken every cycle; the sustained pace is bounded by the output port
// draining one result word per cycle: one input per cycle for single-result words, less
// for two-word ones (disconnects, ticks with a heartbeat or deadman). Configuration
// writes take effect on the next cycle and are expected only while no results wait.
module teleop_session_arbiter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    tsa_in_if.sink                             i_in,
    tsa_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic [tsa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tsa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tsa_pkg::*;

    logic  room;
    logic  accept;
    t_push push;

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    tsa_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (i_in.data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (push)
    );

    tsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_room  (room),
        .o_valid (o_out.valid),
        .o_word  (o_out.data)
    );

endmodule
